[hdl/tbsd_pkg.sv]
// Shared types and constants for the two-byte-sync packet deframer.
`default_nettype none

package tbsd_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned PhaseWidth = 3;
   localparam int unsigned CsrIdxWidth = 1;

   localparam logic [PhaseWidth-1:0] PH_HUNT    = 3'd0;
   localparam logic [PhaseWidth-1:0] PH_SYNC2   = 3'd1;
   localparam logic [PhaseWidth-1:0] PH_OPCODE  = 3'd2;
   localparam logic [PhaseWidth-1:0] PH_LENGTH  = 3'd3;
   localparam logic [PhaseWidth-1:0] PH_PAYLOAD = 3'd4;

   localparam logic [CsrIdxWidth-1:0] CSR_SYNC_FIRST  = 1'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_SYNC_SECOND = 1'd1;

   localparam logic [ByteWidth-1:0] SYNC_FIRST_RST  = 8'h02;
   localparam logic [ByteWidth-1:0] SYNC_SECOND_RST = 8'h1B;

   typedef logic [ByteWidth-1:0] byte_type;

   typedef struct packed {
      logic     valid;
      logic     last;
      byte_type opcode;
      byte_type length;
      byte_type index;
      byte_type data;
   } rsp_type;

endpackage

`default_nettype wire

[hdl/tbsd_parser.sv]
// Header parser state machine: tracks sync, opcode, length and payload position.
`default_nettype none

module tbsd_parser (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             beat,
   input  wire tbsd_pkg::byte_type rx_byte,
   input  wire tbsd_pkg::byte_type sync_first,
   input  wire tbsd_pkg::byte_type sync_second,
   output tbsd_pkg::rsp_type     result
);
   import tbsd_pkg::*;

   logic [PhaseWidth-1:0] phase_ff, phase_in;
   byte_type              opcode_ff, opcode_in;
   byte_type              length_ff, length_in;
   byte_type              count_ff, count_in;
   logic [ByteWidth:0]    count_next;
   logic                  last;

   assign count_next = {1'b0, count_ff} + {{ByteWidth{1'b0}}, 1'b1};
   assign last       = (count_next >= {1'b0, length_ff});

   always_comb begin
      phase_in  = phase_ff;
      opcode_in = opcode_ff;
      length_in = length_ff;
      count_in  = count_ff;
      result    = '0;
      unique case (phase_ff)
         PH_SYNC2: begin
            if (rx_byte == sync_second) phase_in = PH_OPCODE;
         end
         PH_OPCODE: begin
            opcode_in = rx_byte;
            phase_in  = PH_LENGTH;
         end
         PH_LENGTH: begin
            length_in = rx_byte;
            count_in  = '0;
            phase_in  = (rx_byte != '0) ? PH_PAYLOAD : PH_HUNT;
         end
         PH_PAYLOAD: begin
            result.valid  = 1'b1;
            result.last   = last;
            result.opcode = opcode_ff;
            result.length = length_ff;
            result.index  = count_ff;
            result.data   = rx_byte;
            if (last) begin
               phase_in = PH_HUNT;
               count_in = '0;
            end else begin
               count_in = count_next[ByteWidth-1:0];
            end
         end
         default: begin
            phase_in = (rx_byte == sync_first) ? PH_SYNC2 : PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         opcode_ff <= '0;
         length_ff <= '0;
         count_ff  <= '0;
      end else if (beat) begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         length_ff <= length_in;
         count_ff  <= count_in;
      end
   end

   // payload phase never holds a zero length
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> length_ff != '0)
      else $error("payload phase with zero length");

   a_count_below_len: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> count_ff < length_ff)
      else $error("payload count ran past length");

   a_count_reset: assert property (@(posedge clock) disable iff (reset)
      beat && phase_ff == PH_LENGTH && rx_byte != '0 |=> count_ff == '0)
      else $error("byte count not cleared at packet start");

endmodule

`default_nettype wire

[hdl/two_byte_sync_packet_deframer.sv]
// Top level of the two-byte-sync packet deframer: csr, parser and result register.
//
//  channel  direction  beat fields
//  req_     in         tdata[7:0] rx_byte
//  rsp_     out        tdata: opcode, length, index, byte; tlast: last payload byte
//  csr_     in         index 0 sync_first, index 1 sync_second; write only
//
// One beat per cycle unless rsp_ stalls; a payload beat appears on rsp_ in the
// cycle after it is taken. Header and dropped beats produce nothing.
// req_tready drops only while a result is held and rsp_tready is low. Reset is
// synchronous; sync values return to 0x02 and 0x1B, the parser to the hunt.
`default_nettype none

module two_byte_sync_packet_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] packet_opcode, [15:8] packet_length, [23:16] payload_index,
   // [31:24] payload_byte
   output logic [31:0]      rsp_tdata,
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [tbsd_pkg::CsrIdxWidth-1:0] csr_index,
   input  wire logic [7:0]  csr_wdata
);
   import tbsd_pkg::*;

   byte_type sync_first_ff, sync_second_ff;
   rsp_type  result;
   logic     beat;
   logic     rsp_valid_ff;
   logic     rsp_last_ff;
   logic [31:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RST;
         sync_second_ff <= SYNC_SECOND_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SYNC_FIRST:  sync_first_ff  <= csr_wdata;
            CSR_SYNC_SECOND: sync_second_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign beat       = req_tvalid && req_tready;

   tbsd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .beat        (beat),
      .rx_byte     (req_tdata),
      .sync_first  (sync_first_ff),
      .sync_second (sync_second_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (beat) begin
         rsp_valid_ff <= result.valid;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (beat && result.valid) begin
         rsp_data_ff <= {result.data, result.index, result.length, result.opcode};
         rsp_last_ff <= result.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input taken while result stalled");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      beat && result.valid |=> rsp_valid_ff)
      else $error("payload beat lost");

   a_last_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         rsp_last_ff == ({1'b0, rsp_data_ff[23:16]} + 9'd1 == {1'b0, rsp_data_ff[15:8]}))
      else $error("last flag disagrees with index and length");

endmodule

`default_nettype wire

[test/tb.sv]
// Self-checking bench for the two-byte-sync packet deframer: random byte streams, parser model.
`timescale 1ns / 100ps

module tb;
   import tbsd_pkg::*;

   localparam int IdleLimit  = 1000;
   localparam int PhaseItems = 280;

   typedef struct {
      byte_type data;
      bit       drain;
   } rx_beat_type;

   typedef struct {
      byte_type opcode;
      byte_type length;
      byte_type index;
      byte_type data;
      logic     last;
   } payload_beat_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [31:0]            rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_we;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [7:0]             csr_wdata;

   two_byte_sync_packet_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   rx_beat_type      rx_q[$];
   payload_beat_type payload_q[$];
   int               queued_beats;
   int               taken_beats;
   int               mismatches;
   int               idle_cycles;
   bit               calm;
   bit               req_done;

   // parser model state
   byte_type              hunt_first;
   byte_type              hunt_second;
   byte_type              frame_opcode;
   byte_type              frame_length;
   byte_type              payload_count;
   logic [PhaseWidth-1:0] frame_phase;

   // repeated first sync, junk while waiting, zero length, payload equal to sync values
   byte_type opening_bytes [20] = '{
      8'h00, 8'h02, 8'h02, 8'hFF, 8'h1B, 8'hFF, 8'h01, 8'h00,
      8'h02, 8'h1B, 8'h00, 8'h00,
      8'h1B, 8'h02, 8'h1B, 8'hA5, 8'h03, 8'hFF, 8'h02, 8'h1B
   };

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic deframe_byte(input byte_type b);
      payload_beat_type beat;
      logic [8:0]       next;
      case (frame_phase)
         PH_SYNC2: begin
            if (b == hunt_second) frame_phase = PH_OPCODE;
         end
         PH_OPCODE: begin
            frame_opcode = b;
            frame_phase  = PH_LENGTH;
         end
         PH_LENGTH: begin
            frame_length = b;
            if (b != 8'd0) begin
               payload_count = 8'd0;
               frame_phase   = PH_PAYLOAD;
            end else begin
               frame_phase = PH_HUNT;
            end
         end
         PH_PAYLOAD: begin
            next        = {1'b0, payload_count} + 9'd1;
            beat.opcode = frame_opcode;
            beat.length = frame_length;
            beat.index  = payload_count;
            beat.data   = b;
            beat.last   = (next >= {1'b0, frame_length});
            payload_q.push_back(beat);
            if (beat.last) begin
               frame_phase   = PH_HUNT;
               payload_count = 8'd0;
            end else begin
               payload_count = next[7:0];
            end
         end
         default: begin
            frame_phase = (b == hunt_first) ? PH_SYNC2 : PH_HUNT;
         end
      endcase
   endtask

   task automatic push_rx(input byte_type data, input bit drain);
      rx_beat_type beat;
      beat.data  = data;
      beat.drain = drain;
      rx_q.push_back(beat);
      queued_beats++;
   endtask

   // noise, header with optional junk in the sync wait, opcode, length, payload;
   // a few are cut short in the header or the payload
   task automatic queue_packet(input byte_type s1, input byte_type s2, input bit longest);
      int       len;
      byte_type b;
      repeat ($urandom_range(2)) push_rx(8'($urandom_range(255)), 1'b0);
      push_rx(s1, $urandom_range(39) == 0);
      repeat (($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0) begin
         b = $urandom_range(1) ? s1 : 8'($urandom_range(255));
         push_rx((b == s2) ? ~s2 : b, 1'b0);
      end
      if ($urandom_range(19) == 0) return;
      push_rx(s2, 1'b0);
      push_rx(8'($urandom_range(255)), 1'b0);
      case ($urandom_range(99)) inside
         [0:9]:   len = 0;
         [10:19]: len = $urandom_range(64, 13);
         default: len = $urandom_range(12, 1);
      endcase
      if (longest) len = 255;
      push_rx(8'(len), 1'b0);
      if (len != 0 && $urandom_range(19) == 0) len = $urandom_range(len - 1, 0);
      repeat (len) push_rx(8'($urandom_range(255)), 1'b0);
   endtask

   task automatic write_syncs(input byte_type first, input byte_type second);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_SYNC_FIRST;
      csr_wdata <= first;
      @(negedge clock);
      csr_index <= CSR_SYNC_SECOND;
      csr_wdata <= second;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic wait_drained();
      while (taken_beats != queued_beats || payload_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   always @(negedge clock) begin : driver
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 36);
         if (!req_tvalid || req_done) begin
            if (rx_q.size() != 0 && (calm || $urandom_range(99) >= 36)
                && !(rx_q[0].drain && payload_q.size() != 0)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= rx_q[0].data;
               void'(rx_q.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      payload_beat_type want;
      if (reset) begin
         hunt_first    = SYNC_FIRST_RST;
         hunt_second   = SYNC_SECOND_RST;
         frame_phase   = PH_HUNT;
         frame_opcode  = 8'd0;
         frame_length  = 8'd0;
         payload_count = 8'd0;
         idle_cycles   = 0;
         req_done     <= 1'b0;
      end else begin
         req_done <= req_tvalid && req_tready;
         if (csr_we) begin
            if (csr_index == CSR_SYNC_FIRST) hunt_first = csr_wdata;
            else if (csr_index == CSR_SYNC_SECOND) hunt_second = csr_wdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (payload_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: payload beat with none expected: tdata %h tlast %b",
                           $time, rsp_tdata, rsp_tlast);
            end else begin
               want = payload_q.pop_front();
               if (rsp_tdata[7:0] !== want.opcode || rsp_tdata[15:8] !== want.length
                   || rsp_tdata[23:16] !== want.index || rsp_tdata[31:24] !== want.data
                   || rsp_tlast !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: exp op %h len %h idx %h byte %h last %b got %h %h %h %h %b",
                              $time, want.opcode, want.length, want.index, want.data,
                              want.last, rsp_tdata[7:0], rsp_tdata[15:8],
                              rsp_tdata[23:16], rsp_tdata[31:24], rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            deframe_byte(req_tdata);
            taken_beats++;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("two_byte_sync_packet_deframer regression: fail");
            $finish;
         end
      end
   end

   initial begin : stimulus
      byte_type first_sync;
      byte_type second_sync;
      int       phase_start;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = 8'd0;
      rsp_tready   = 1'b0;
      csr_we       = 1'b0;
      csr_index    = CSR_SYNC_FIRST;
      csr_wdata    = 8'd0;
      calm         = 1'b0;
      queued_beats = 0;
      taken_beats  = 0;
      mismatches   = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (opening_bytes[i]) push_rx(opening_bytes[i], 1'b0);
      wait_drained();

      for (int p = 0; p < 7; p++) begin
         case (p)
            0: begin
               first_sync  = 8'h00;
               second_sync = 8'hFF;
            end
            1: begin
               first_sync  = 8'hFF;
               second_sync = 8'h00;
            end
            2: begin
               first_sync  = 8'($urandom_range(255));
               second_sync = first_sync;
            end
            6: begin
               first_sync  = SYNC_FIRST_RST;
               second_sync = SYNC_SECOND_RST;
            end
            default: begin
               first_sync  = 8'($urandom_range(255));
               second_sync = 8'($urandom_range(255));
            end
         endcase
         write_syncs(first_sync, second_sync);
         calm        = (p == 3);
         phase_start = queued_beats;
         queue_packet(first_sync, second_sync, p == 1 || p == 4);
         while (queued_beats - phase_start < PhaseItems)
            queue_packet(first_sync, second_sync, 1'b0);
         wait_drained();
      end
      calm = 1'b0;

      repeat (8) @(negedge clock);
      if (mismatches == 0 && payload_q.size() == 0)
         $display("two_byte_sync_packet_deframer regression: pass");
      else
         $display("two_byte_sync_packet_deframer regression: fail");
      $finish;
   end

endmodule
